// ----- hdl/sfop_pkg.sv -----
// ----------------------------------------------------------------------------
// sfop_pkg
// Shared types, constants and the character coder of the odd-parity framer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfop_pkg;

  localparam int FRAME_CHARS = 4;
  localparam int CNT_W       = $clog2(FRAME_CHARS + 1);
  localparam int IDX_W       = (FRAME_CHARS > 1) ? $clog2(FRAME_CHARS) : 1;
  localparam int POS_W       = $clog2(FRAME_CHARS + 3);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] SYNC_BYTE = 8'h16;

  localparam logic FUNC_CHAR  = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic [CNT_W-1:0]            cnt;
    logic [FRAME_CHARS-1:0][7:0] data;
  } frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // seven data bits shifted up, odd parity in bit 0
  function automatic logic [7:0] code_char(input logic [7:0] c);
    return {c[6:0], ~^c[6:0]};
  endfunction

endpackage

`default_nettype wire

// ----- hdl/sync_framer_odd_parity.sv -----
// ----------------------------------------------------------------------------
// sync_framer_odd_parity
// Groups odd-parity coded characters into sync frames of up to four.
// ----------------------------------------------------------------------------
//   channel  handshake            payload
//   in       in_valid / in_stall  func, char_in
//   out      out_valid/out_stall  frame_byte, last_of_frame
//
// an item can be taken every cycle unless the input stalls; a frame leaves at
// one byte a cycle while out_stall is low, as two sync bytes, a count byte and
// its characters, so the output port sets the pace.
// the input stalls only when an item would close a frame and both queue
// slots are taken. reset is synchronous and drops pending characters,
// queued frames and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_framer_odd_parity (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       func,
  input  wire logic [7:0] char_in,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      frame_byte,
  output logic            last_of_frame
);

  sfop_pkg::frame_t push_frame;
  sfop_pkg::frame_t head;
  sfop_pkg::qstat_t q_stat;
  logic             push;
  logic             pop;

  sfop_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (func),
    .char_in    (char_in),
    .q_stat     (q_stat),
    .push       (push),
    .push_frame (push_frame)
  );

  sfop_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_frame (push_frame),
    .pop        (pop),
    .head       (head),
    .q_stat     (q_stat)
  );

  sfop_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .q_stat        (q_stat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .last_of_frame (last_of_frame)
  );

`ifndef SYNTH
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    !(push && q_stat.full && !pop))
    else $error("frame pushed into full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && q_stat.empty))
    else $error("frame popped from empty queue");

  a_sync_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_frame) |=>
      (!out_valid || frame_byte == sfop_pkg::SYNC_BYTE))
    else $error("frame does not open with sync byte");
`endif

endmodule

`default_nettype wire

// ----- hdl/sfop_front.sv -----
// ----------------------------------------------------------------------------
// sfop_front
// Accepts items, codes characters and collects them; hands complete or
// flushed frames to the frame queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sfop_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              func,
  input  wire logic [7:0]        char_in,
  input  wire sfop_pkg::qstat_t  q_stat,
  output logic                   push,
  output sfop_pkg::frame_t       push_frame
);

  logic [sfop_pkg::CNT_W-1:0] count;
  logic [7:0]                 pending [sfop_pkg::FRAME_CHARS];
  logic [7:0]                 coded;
  logic                       is_char;
  logic                       completes;
  logic                       makes_frame;
  logic                       accept;

  always_comb begin
    coded       = sfop_pkg::code_char(char_in);
    is_char     = (func == sfop_pkg::FUNC_CHAR);
    completes   = (count == sfop_pkg::CNT_W'(sfop_pkg::FRAME_CHARS - 1));
    makes_frame = is_char ? completes : (count != '0);
    in_stall    = q_stat.full && makes_frame;
    accept      = in_valid && !in_stall;
    push        = accept && makes_frame;

    push_frame.cnt = is_char ? sfop_pkg::CNT_W'(sfop_pkg::FRAME_CHARS) : count;
    for (int i = 0; i < sfop_pkg::FRAME_CHARS; i++) begin
      // the completing character goes straight into the frame
      push_frame.data[i] = (is_char && (sfop_pkg::CNT_W'(i) == count)) ? coded : pending[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (accept) begin
      if (!is_char || completes) begin
        count <= '0;
      end else begin
        count <= count + sfop_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && is_char) begin
      pending[count[sfop_pkg::IDX_W-1:0]] <= coded;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfop_queue.sv -----
// ----------------------------------------------------------------------------
// sfop_queue
// Short queue of whole frames between the front and the byte sender.
// ----------------------------------------------------------------------------
`default_nettype none

module sfop_queue (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire sfop_pkg::frame_t  push_frame,
  input  wire logic              pop,
  output sfop_pkg::frame_t       head,
  output sfop_pkg::qstat_t       q_stat
);

  sfop_pkg::frame_t            slots [sfop_pkg::QUEUE_DEPTH];
  logic [sfop_pkg::QPTR_W-1:0] wr_ptr;
  logic [sfop_pkg::QPTR_W-1:0] rd_ptr;
  logic [sfop_pkg::QCNT_W-1:0] fill;

  function automatic logic [sfop_pkg::QPTR_W-1:0] bump(input logic [sfop_pkg::QPTR_W-1:0] p);
    return (p == sfop_pkg::QPTR_W'(sfop_pkg::QUEUE_DEPTH - 1)) ? '0 : p + sfop_pkg::QPTR_W'(1);
  endfunction

  always_comb begin
    head         = slots[rd_ptr];
    q_stat.full  = (fill == sfop_pkg::QCNT_W'(sfop_pkg::QUEUE_DEPTH));
    q_stat.empty = (fill == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        fill <= fill + sfop_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - sfop_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_frame;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/sfop_back.sv -----
// ----------------------------------------------------------------------------
// sfop_back
// Sends the frame at the queue head one byte a cycle while out_stall is low:
// two sync bytes, the count, then the data bytes, with the last byte marked.
// ----------------------------------------------------------------------------
`default_nettype none

module sfop_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire sfop_pkg::frame_t  head,
  input  wire sfop_pkg::qstat_t  q_stat,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             frame_byte,
  output logic                   last_of_frame
);

  logic [sfop_pkg::POS_W-1:0] pos;
  logic [sfop_pkg::POS_W-1:0] data_pos;
  logic                       load;
  logic                       is_last;
  logic [7:0]                 byte_next;

  always_comb begin
    load     = !q_stat.empty && (!out_valid || !out_stall);
    data_pos = pos - sfop_pkg::POS_W'(3);
    is_last  = (pos == sfop_pkg::POS_W'(head.cnt) + sfop_pkg::POS_W'(2));
    pop      = load && is_last;
    if (pos < sfop_pkg::POS_W'(2)) begin
      byte_next = sfop_pkg::SYNC_BYTE;
    end else if (pos == sfop_pkg::POS_W'(2)) begin
      byte_next = 8'(head.cnt);
    end else begin
      byte_next = head.data[data_pos[sfop_pkg::IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        pos       <= is_last ? '0 : pos + sfop_pkg::POS_W'(1);
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_byte    <= byte_next;
      last_of_frame <= is_last;
    end
  end

endmodule

`default_nettype wire

// ----- sim/sync_framer_odd_parity_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_framer_odd_parity_tb
// Checks the odd-parity sync framer against a frame predictor in the bench.
// Directed tests cover an empty flush, full frames, a flush straight after a
// full frame and partial frames of every length. A long random stream of
// character runs and flushes follows. Both handshakes idle and stall at
// random. Every accepted frame byte is compared with the oldest predicted one.
// ----------------------------------------------------------------------------

module sync_framer_odd_parity_tb;

  localparam int STUCK_LIMIT  = 2000;
  localparam int MAX_GAP      = 13;
  localparam int RANDOM_ITEMS = 210;

  typedef struct packed {
    logic [7:0] fbyte;
    logic       last;
  } frame_out_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       func = sfop_pkg::FUNC_CHAR;
  logic [7:0] char_in = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic       last_of_frame;

  frame_out_t frame_bytes_due[$];
  logic [7:0] held_code [sfop_pkg::FRAME_CHARS];
  logic [2:0] held_cnt;
  int         errors = 0;
  int         stuck_cycles = 0;
  int         items_sent = 0;
  bit         send_quiet = 1'b0;
  bit         recv_quiet = 1'b0;

  sync_framer_odd_parity DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .char_in       (char_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .frame_byte    (frame_byte),
    .last_of_frame (last_of_frame)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // low seven bits moved up, bit 0 set when they hold an even number of ones
  function automatic logic [7:0] parity_code(input logic [7:0] c);
    int ones;
    ones = 0;
    for (int i = 0; i < 7; i++) ones += c[i];
    return {c[6:0], (ones % 2 == 0)};
  endfunction

  function automatic void emit_held_frame();
    frame_out_t r;
    if (held_cnt == 0) return;
    r.last  = 1'b0;
    r.fbyte = sfop_pkg::SYNC_BYTE;
    frame_bytes_due.push_back(r);
    frame_bytes_due.push_back(r);
    r.fbyte = {5'b00000, held_cnt};
    frame_bytes_due.push_back(r);
    for (int i = 0; i < held_cnt; i++) begin
      r.fbyte = held_code[i];
      r.last  = (i == held_cnt - 1);
      frame_bytes_due.push_back(r);
    end
    held_cnt = '0;
  endfunction

  function automatic void predict_frame_bytes(input logic f, input logic [7:0] c);
    if (f == sfop_pkg::FUNC_FLUSH) begin
      emit_held_frame();
    end else begin
      held_code[held_cnt[1:0]] = parity_code(c);
      held_cnt++;
      if (held_cnt == sfop_pkg::FRAME_CHARS) emit_held_frame();
    end
  endfunction

  // entered and left at a falling edge; valid stays up for a back-to-back item
  task automatic send_item(input logic f, input logic [7:0] c);
    int gap;
    if ($urandom_range(0, 29) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    char_in  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_frame_bytes(f, c);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_frames_out();
    in_valid <= 1'b0;
    while (frame_bytes_due.size() != 0) @(negedge clk);
  endtask

  task automatic test_flush_when_empty();
    send_item(sfop_pkg::FUNC_FLUSH, 8'h00);
    send_item(sfop_pkg::FUNC_FLUSH, 8'hFF);
    wait_frames_out();
  endtask

  task automatic test_full_frames();
    // parity extremes, high bit clear and set
    send_item(sfop_pkg::FUNC_CHAR, 8'h00);
    send_item(sfop_pkg::FUNC_CHAR, 8'h7F);
    send_item(sfop_pkg::FUNC_CHAR, 8'h80);
    send_item(sfop_pkg::FUNC_CHAR, 8'hFF);
    // nothing pending after a full frame
    send_item(sfop_pkg::FUNC_FLUSH, 8'hA5);
    send_item(sfop_pkg::FUNC_CHAR, 8'h01);
    send_item(sfop_pkg::FUNC_CHAR, 8'h55);
    send_item(sfop_pkg::FUNC_CHAR, 8'hAA);
    send_item(sfop_pkg::FUNC_CHAR, 8'hC3);
    wait_frames_out();
  endtask

  task automatic test_partial_frames();
    for (int n = 1; n < sfop_pkg::FRAME_CHARS; n++) begin
      for (int k = 0; k < n; k++) send_item(sfop_pkg::FUNC_CHAR, 8'($urandom_range(0, 255)));
      send_item(sfop_pkg::FUNC_FLUSH, 8'hFF);
    end
    wait_frames_out();
  endtask

  task automatic test_random_stream();
    int         target;
    int         run;
    logic [7:0] c;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      run = $urandom_range(0, 6);
      for (int k = 0; k < run; k++) begin
        case ($urandom_range(0, 9))
          0: c = 8'h00;
          1: c = 8'hFF;
          default: c = 8'($urandom_range(0, 255));
        endcase
        send_item(sfop_pkg::FUNC_CHAR, c);
      end
      if ($urandom_range(0, 3) != 0) begin
        send_item(sfop_pkg::FUNC_FLUSH, 8'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 15) == 0) wait_frames_out();
    end
    wait_frames_out();
  endtask

  initial begin
    held_cnt = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_flush_when_empty();
    test_full_frames();
    test_partial_frames();
    test_random_stream();
    repeat (30) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // frame byte receiver and checker
  initial begin
    int         hold;
    frame_out_t want;
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 39) == 0) recv_quiet = !recv_quiet;
      hold = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      if (frame_bytes_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, frame_byte %h last_of_frame %b",
                 $time, frame_byte, last_of_frame);
      end else begin
        want = frame_bytes_due.pop_front();
        if (frame_byte !== want.fbyte) begin
          errors++;
          $display("%0t: frame_byte expected %h actual %h", $time, want.fbyte, frame_byte);
        end
        if (last_of_frame !== want.last) begin
          errors++;
          $display("%0t: last_of_frame expected %b actual %b",
                   $time, want.last, last_of_frame);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ----- filelist.f -----
hdl/sfop_pkg.sv
hdl/sfop_front.sv
hdl/sfop_queue.sv
hdl/sfop_back.sv
hdl/sync_framer_odd_parity.sv
sim/sync_framer_odd_parity_tb.sv
